// ===== design/ring_slot_transmit_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Ring slot transmit sequencer assertion macros
// Shared property macros for the checker; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RING_SLOT_TRANSMIT_SEQUENCER_ASSERT_SVH
`define RING_SLOT_TRANSMIT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define RSTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring slot sequencer: same-cycle check failed");

// next-cycle implication
`define RSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring slot sequencer: next-cycle check failed");

`endif

// ===== design/rsts_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring slot transmit sequencer package
// Widths, register indexes and node state codes shared by the design files.
// ----------------------------------------------------------------------------
package rsts_pkg;

  // field widths
  localparam int TIME_BITS     = 32;
  localparam int ID_BITS       = 8;
  localparam int COUNT_BITS    = ID_BITS + 1;
  localparam int DELAY_BITS    = TIME_BITS - 1;
  localparam int STATE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = TIME_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_ID           = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE_DEADLINE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSMIT_DELAY   = 2'd3;

  // configuration reset values
  localparam logic [ID_BITS-1:0]    OWN_ID_RST    = '0;
  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RST = COUNT_BITS'(4);
  localparam logic [TIME_BITS-1:0]  DEADLINE_RST  = TIME_BITS'(1000);
  localparam logic [DELAY_BITS-1:0] DELAY_RST     = DELAY_BITS'(100);

  // node state codes as seen on the result beat
  localparam logic [STATE_BITS-1:0] NODE_IDLE     = 2'd0;
  localparam logic [STATE_BITS-1:0] NODE_SENDING  = 2'd1;
  localparam logic [STATE_BITS-1:0] NODE_CHECKING = 2'd2;
  localparam logic [STATE_BITS-1:0] NODE_RETRYING = 2'd3;

endpackage

// ===== design/rsts_if.sv =====
// ----------------------------------------------------------------------------
// Ring slot transmit sequencer channels
// Tick input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// tick channel: time plus an optional received packet
interface rsts_in_if;
  import rsts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic                 packet_valid;
  logic [ID_BITS-1:0]   packet_sender;
  logic                 packet_good;

  modport source (output valid, output now_ms, output packet_valid,
                  output packet_sender, output packet_good, input ready);
  modport sink   (input valid, input now_ms, input packet_valid,
                  input packet_sender, input packet_good, output ready);
endinterface

// result channel: node state, ping pulse and light level
interface rsts_out_if;
  import rsts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATE_BITS-1:0] node_state;
  logic                  ping_fire;
  logic                  led_on;

  modport source (output valid, output node_state, output ping_fire,
                  output led_on, input ready);
  modport sink   (input valid, input node_state, input ping_fire,
                  input led_on, output ready);
endinterface

// ===== design/ring_slot_transmit_sequencer.sv =====
// ----------------------------------------------------------------------------
// Ring slot transmit sequencer
// One node of a round-robin transmit ring: idle, sending, checking, retrying.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                        | beat
//  ---------+-----+------------------------------------------------+-------------
//  in_ch    | in  | now_ms, packet_valid, packet_sender, packet_good | one tick
//  out_ch   | out | node_state, ping_fire, led_on                  | one result
//  cfg_*    | in  | cfg_index, cfg_wdata                           | one write
//
//  a tick beat passes through the tick register, then the state update and
//  result register; one tick is accepted every cycle unless out_ch stalls,
//  and the single state update per tick sets it
//  a stall on out_ch holds both stages; in_ch.ready drops only when both hold
//  synchronous active-low reset puts the node in idle with all timers at zero
//  and the configuration registers at their defaults
//
module ring_slot_transmit_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rsts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rsts_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  rsts_in_if.sink                        in_ch,
  rsts_out_if.source                     out_ch
);
  import rsts_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_SENDING  = 4'b0010,
    MODE_CHECKING = 4'b0100,
    MODE_RETRYING = 4'b1000
  } mode_t;

  // configuration registers
  logic [ID_BITS-1:0]    own_id_r;
  logic [COUNT_BITS-1:0] node_count_r;
  logic [TIME_BITS-1:0]  deadline_r;
  logic [DELAY_BITS-1:0] delay_r;

  // tick register
  logic                 tick_vld_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 pkt_vld_r;
  logic [ID_BITS-1:0]   sender_r;
  logic                 good_r;

  // node state
  mode_t                mode_r, mode_nxt;
  logic [TIME_BITS-1:0] last_good_r, last_good_nxt;
  logic [TIME_BITS-1:0] wait_start_r, wait_start_nxt;
  logic                 started_r, started_nxt;
  logic [TIME_BITS-1:0] last_ping_r, last_ping_nxt;
  logic                 led_r, led_nxt;
  logic                 ping_nxt;

  // result register
  logic                  out_vld_r;
  logic [STATE_BITS-1:0] out_state_r, out_state_nxt;
  logic                  out_ping_r;
  logic                  out_led_r;

  logic advance;
  logic in_take;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= OWN_ID_RST;
      node_count_r <= NODE_COUNT_RST;
      deadline_r   <= DEADLINE_RST;
      delay_r      <= DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:           own_id_r     <= cfg_wdata[ID_BITS-1:0];
        CFG_NODE_COUNT:       node_count_r <= cfg_wdata[COUNT_BITS-1:0];
        CFG_SILENCE_DEADLINE: deadline_r   <= cfg_wdata[TIME_BITS-1:0];
        CFG_TRANSMIT_DELAY:   delay_r      <= cfg_wdata[DELAY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: stages advance when out_ch frees; an empty tick stage fills too
  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !tick_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      tick_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      now_r     <= in_ch.now_ms;
      pkt_vld_r <= in_ch.packet_valid;
      sender_r  <= in_ch.packet_sender;
      good_r    <= in_ch.packet_good;
    end
  end

  // per-tick state update
  always_comb begin
    logic [TIME_BITS-1:0] wait_ref;
    logic                 pred_match;
    mode_nxt       = mode_r;
    last_good_nxt  = last_good_r;
    wait_start_nxt = wait_start_r;
    started_nxt    = started_r;
    last_ping_nxt  = last_ping_r;
    led_nxt        = led_r;
    ping_nxt       = 1'b0;
    wait_ref       = started_r ? wait_start_r : now_r;
    pred_match     = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        if (own_id_r == '0) begin
          pred_match = (node_count_r != '0) &&
                       (sender_r == ID_BITS'(node_count_r - COUNT_BITS'(1)));
        end else begin
          pred_match = (sender_r == ID_BITS'(own_id_r - ID_BITS'(1)));
        end
        // a bad packet ends the tick before the silence check
        if (!(pkt_vld_r && !good_r)) begin
          if (pkt_vld_r) begin
            last_good_nxt = now_r;
            if (pred_match) begin
              mode_nxt = MODE_SENDING;
            end
          end
          if ((own_id_r == '0) &&
              (TIME_BITS'(now_r - (pkt_vld_r ? now_r : last_good_r)) > deadline_r)) begin
            mode_nxt = MODE_SENDING;
          end
        end
      end
      MODE_SENDING: begin
        if (!started_r) begin
          wait_start_nxt = now_r;
          led_nxt        = 1'b1;
        end
        started_nxt = 1'b1;
        if (TIME_BITS'(now_r - wait_ref) < {1'b0, delay_r}) begin
          if (pkt_vld_r) begin
            mode_nxt    = MODE_IDLE;
            started_nxt = 1'b0;
          end
        end else begin
          started_nxt   = 1'b0;
          led_nxt       = 1'b0;
          last_ping_nxt = now_r;
          mode_nxt      = MODE_CHECKING;
          ping_nxt      = 1'b1;
        end
      end
      MODE_CHECKING: begin
        if (pkt_vld_r) begin
          mode_nxt = MODE_IDLE;
        end
        // the confirm timeout wins over a packet
        if (TIME_BITS'(now_r - last_ping_r) > {delay_r, 1'b0}) begin
          mode_nxt = MODE_RETRYING;
        end
      end
      MODE_RETRYING: begin
        led_nxt       = 1'b0;
        last_ping_nxt = now_r;
        mode_nxt      = MODE_CHECKING;
        ping_nxt      = 1'b1;
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // node state code for the result beat
  always_comb begin
    case (mode_nxt)
      MODE_IDLE:     out_state_nxt = NODE_IDLE;
      MODE_SENDING:  out_state_nxt = NODE_SENDING;
      MODE_CHECKING: out_state_nxt = NODE_CHECKING;
      MODE_RETRYING: out_state_nxt = NODE_RETRYING;
      default:       out_state_nxt = NODE_IDLE;
    endcase
  end

  // state registers, committed as the tick moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      last_good_r  <= '0;
      wait_start_r <= '0;
      started_r    <= 1'b0;
      last_ping_r  <= '0;
      led_r        <= 1'b0;
    end else if (advance && tick_vld_r) begin
      mode_r       <= mode_nxt;
      last_good_r  <= last_good_nxt;
      wait_start_r <= wait_start_nxt;
      started_r    <= started_nxt;
      last_ping_r  <= last_ping_nxt;
      led_r        <= led_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= tick_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_vld_r) begin
      out_state_r <= out_state_nxt;
      out_ping_r  <= ping_nxt;
      out_led_r   <= led_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.node_state = out_state_r;
  assign out_ch.ping_fire  = out_ping_r;
  assign out_ch.led_on     = out_led_r;

endmodule

// ===== design/rsts_checker.sv =====
// ----------------------------------------------------------------------------
// Ring slot transmit sequencer checker
// Port-level properties of the result channel, bound to the sequencer.
// ----------------------------------------------------------------------------
`include "ring_slot_transmit_sequencer_assert.svh"

module rsts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rsts_pkg::STATE_BITS-1:0] out_node_state,
  input logic                            out_ping_fire,
  input logic                            out_led_on
);
  import rsts_pkg::*;

  logic                  ping_beat;
  logic                  confirm_beat;
  logic [STATE_BITS+1:0] out_payload;

  // result beat qualifiers
  assign ping_beat    = out_valid && out_ping_fire;
  assign confirm_beat = out_valid &&
                        (out_node_state == NODE_CHECKING || out_node_state == NODE_RETRYING);
  assign out_payload  = {out_node_state, out_ping_fire, out_led_on};

  // a ping always lands the node in checking
  `RSTS_ASSERT_NOW(a_ping_to_checking, ping_beat, out_node_state == NODE_CHECKING)

  // the light goes off with every ping
  `RSTS_ASSERT_NOW(a_ping_led_off, ping_beat, !out_led_on)

  // while waiting for a confirm or retrying, the light stays off
  `RSTS_ASSERT_NOW(a_confirm_led_off, confirm_beat, !out_led_on)

  // a stalled result beat holds
  `RSTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

endmodule

bind ring_slot_transmit_sequencer rsts_checker u_rsts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_node_state (out_ch.node_state),
  .out_ping_fire  (out_ch.ping_fire),
  .out_led_on     (out_ch.led_on)
);
